@@ hdl/kuf_pkg.sv @@
// shared types and constants for the union-find spanning-tree engine
`timescale 1ns / 1ps

package kuf_pkg;

  // fixed field widths
  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int RANK_W  = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // one finished result word from the sequencer
  typedef struct packed {
    logic               tree_edge;
    logic [COUNT_W-1:0] components_left;
    logic               bad_index;
  } kuf_result_t;

endpackage

@@ hdl/kuf_mem.sv @@
// forest table memory: one write port, one registered read port, write-first
`timescale 1ns / 1ps

module kuf_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 14,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read with bypass of a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/kuf_ctrl.sv @@
// sequencer: clearing pass, root walks, path compression and union by rank
`timescale 1ns / 1ps

module kuf_ctrl
  import kuf_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  localparam int IDX_W = $clog2(MAX_NODES),
  localparam int CNT_W = $clog2(MAX_NODES + 1),
  localparam int MEM_W = IDX_W + RANK_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               node_count_we,
  input  logic [COUNT_W-1:0] node_count,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NODE_W-1:0]  first_node,
  input  logic [NODE_W-1:0]  second_node,
  output logic               res_valid,
  input  logic               res_ready,
  output kuf_result_t        res,
  output logic               mem_we,
  output logic [IDX_W-1:0]   mem_waddr,
  output logic [MEM_W-1:0]   mem_wdata,
  output logic [IDX_W-1:0]   mem_raddr,
  input  logic [MEM_W-1:0]   mem_rdata
);

  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_COMP  = 7'b0001000,
    S_LINK  = 7'b0010000,
    S_RANK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic               phase, phase_next;
  logic [IDX_W-1:0]   clr_idx, clr_idx_next;
  logic [IDX_W-1:0]   node_a, node_a_next, node_b, node_b_next;
  logic [IDX_W-1:0]   cur, cur_next, comp_n, comp_n_next;
  logic [IDX_W-1:0]   root_a, root_a_next, root_b, root_b_next;
  logic [RANK_W-1:0]  rank_a, rank_a_next, rank_b, rank_b_next;
  logic               tree, tree_next, bad, bad_next;
  logic [CNT_W-1:0]   nodes, nodes_next, comp_count, comp_count_next;

  logic [IDX_W-1:0]   rd_parent;
  logic [RANK_W-1:0]  rd_rank;
  logic [IDX_W-1:0]   start_node, root_cur;
  logic [CMP_W-1:0]   cfg_value, cfg_sat;
  logic               index_bad;

  assign rd_parent  = mem_rdata[MEM_W-1:RANK_W];
  assign rd_rank    = mem_rdata[RANK_W-1:0];
  assign start_node = phase ? node_b : node_a;
  assign root_cur   = phase ? root_b : root_a;

  // saturate the written node count into one to MAX_NODES
  assign cfg_value = CMP_W'(node_count);
  always_comb begin
    if (cfg_value == '0) begin
      cfg_sat = CMP_W'(1);
    end else if (cfg_value > CMP_W'(MAX_NODES)) begin
      cfg_sat = CMP_W'(MAX_NODES);
    end else begin
      cfg_sat = cfg_value;
    end
  end

  // endpoint range check
  assign index_bad = (CMP_W'(first_node) >= CMP_W'(nodes)) ||
                     (CMP_W'(second_node) >= CMP_W'(nodes));

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.tree_edge       = tree;
  assign res.components_left = COUNT_W'(comp_count);
  assign res.bad_index       = bad;

  // next state and table access
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    clr_idx_next    = clr_idx;
    node_a_next     = node_a;
    node_b_next     = node_b;
    cur_next        = cur;
    comp_n_next     = comp_n;
    root_a_next     = root_a;
    root_b_next     = root_b;
    rank_a_next     = rank_a;
    rank_b_next     = rank_b;
    tree_next       = tree;
    bad_next        = bad;
    nodes_next      = nodes;
    comp_count_next = comp_count;
    mem_we          = 1'b0;
    mem_waddr       = comp_n;
    mem_wdata       = {root_cur, rd_rank};
    mem_raddr       = cur;

    case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        mem_wdata    = {clr_idx, {RANK_W{1'b0}}};
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_IDX) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (index_bad) begin
            bad_next   = 1'b1;
            tree_next  = 1'b0;
            state_next = S_DONE;
          end else begin
            bad_next    = 1'b0;
            tree_next   = 1'b0;
            phase_next  = 1'b0;
            node_a_next = IDX_W'(first_node);
            node_b_next = IDX_W'(second_node);
            cur_next    = IDX_W'(first_node);
            mem_raddr   = IDX_W'(first_node);
            state_next  = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (rd_parent == cur) begin
          // root reached
          if (!phase) begin
            root_a_next = cur;
            rank_a_next = rd_rank;
          end else begin
            root_b_next = cur;
            rank_b_next = rd_rank;
          end
          if (start_node != cur) begin
            comp_n_next = start_node;
            mem_raddr   = start_node;
            state_next  = S_COMP;
          end else if (!phase) begin
            phase_next = 1'b1;
            cur_next   = node_b;
            mem_raddr  = node_b;
          end else begin
            state_next = S_LINK;
          end
        end else begin
          cur_next  = rd_parent;
          mem_raddr = rd_parent;
        end
      end
      S_COMP: begin
        // point the visited node straight at its root
        mem_we    = 1'b1;
        mem_waddr = comp_n;
        mem_wdata = {root_cur, rd_rank};
        if (rd_parent != root_cur) begin
          comp_n_next = rd_parent;
          mem_raddr   = rd_parent;
        end else if (!phase) begin
          phase_next = 1'b1;
          cur_next   = node_b;
          mem_raddr  = node_b;
          state_next = S_WALK;
        end else begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        state_next = S_DONE;
        if (root_a != root_b) begin
          tree_next = 1'b1;
          if (comp_count > CNT_W'(1)) begin
            comp_count_next = comp_count - 1'b1;
          end
          mem_we = 1'b1;
          if (rank_b > rank_a) begin
            mem_waddr = root_a;
            mem_wdata = {root_b, rank_a};
          end else begin
            mem_waddr = root_b;
            mem_wdata = {root_a, rank_b};
            if (rank_a == rank_b) begin
              state_next = S_RANK;
            end
          end
        end
      end
      S_RANK: begin
        // equal ranks: the first root grows, saturating
        mem_we     = 1'b1;
        mem_waddr  = root_a;
        mem_wdata  = {root_a, (rank_a == RANK_MAX) ? RANK_MAX : rank_a + 1'b1};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // node count write restarts the clearing pass
    if (node_count_we) begin
      nodes_next      = CNT_W'(cfg_sat);
      comp_count_next = CNT_W'(cfg_sat);
      clr_idx_next    = '0;
      state_next      = S_CLEAR;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      phase      <= 1'b0;
      clr_idx    <= '0;
      nodes      <= CNT_W'(MAX_NODES);
      comp_count <= CNT_W'(MAX_NODES);
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      clr_idx    <= clr_idx_next;
      nodes      <= nodes_next;
      comp_count <= comp_count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    node_a <= node_a_next;
    node_b <= node_b_next;
    cur    <= cur_next;
    comp_n <= comp_n_next;
    root_a <= root_a_next;
    root_b <= root_b_next;
    rank_a <= rank_a_next;
    rank_b <= rank_b_next;
    tree   <= tree_next;
    bad    <= bad_next;
  end

endmodule

@@ hdl/kruskal_union_find_forest.sv @@
// top level of the union-find spanning-tree engine with its output register
`timescale 1ns / 1ps

// Kruskal spanning-tree engine. Feed edges sorted by ascending weight; each
// edge word gives two end nodes and returns one word with the tree-edge flag,
// the component count after the edge and a bad-index flag. An edge walks
// from both ends to their roots, rewrites the visited nodes by path
// compression, links the roots, and writes one more entry when two
// equal-rank trees merge; an edge with a bad index goes straight to its
// result word. Its run time is set by the single table memory port pair,
// which the sequencer walks one entry per cycle.
// After reset and after every node_count write the table is swept to
// singletons over every entry, during which no edge is taken. A finished
// word waits in the output register while the next edge is taken.

module kruskal_union_find_forest
  import kuf_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               node_count_we,
  input  logic [COUNT_W-1:0] node_count,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [NODE_W-1:0]  first_node,
  input  logic [NODE_W-1:0]  second_node,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               tree_edge,
  output logic [COUNT_W-1:0] components_left,
  output logic               bad_index
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int MEM_W = IDX_W + RANK_W;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [MEM_W-1:0]   mem_wdata, mem_rdata;
  logic               res_valid, res_ready;
  kuf_result_t        res;

  // forest table: parent index over rank
  kuf_mem #(
    .DEPTH (MAX_NODES),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  kuf_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .node_count_we (node_count_we),
    .node_count    (node_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .first_node    (first_node),
    .second_node   (second_node),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  // output word register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      tree_edge       <= res.tree_edge;
      components_left <= res.components_left;
      bad_index       <= res.bad_index;
    end
  end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the union-find spanning-tree engine
`timescale 1ns / 1ps

module testbench;
  import kuf_pkg::*;

  localparam int MAX_NODES   = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               node_count_we = 1'b0;
  logic [COUNT_W-1:0] node_count = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [NODE_W-1:0]  first_node = '0;
  logic [NODE_W-1:0]  second_node = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               tree_edge;
  logic [COUNT_W-1:0] components_left;
  logic               bad_index;

  // predicted forest and pending result words
  logic [NODE_W-1:0]  parent_of [MAX_NODES];
  logic [RANK_W-1:0]  rank_of [MAX_NODES];
  logic [COUNT_W-1:0] live_components;
  logic [COUNT_W-1:0] active_nodes;
  kuf_result_t        pending_results [$];

  int  mismatches = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;

  kruskal_union_find_forest #(.MAX_NODES(MAX_NODES)) u_top (
    .clk             (clk),
    .rst             (rst),
    .node_count_we   (node_count_we),
    .node_count      (node_count),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .first_node      (first_node),
    .second_node     (second_node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .tree_edge       (tree_edge),
    .components_left (components_left),
    .bad_index       (bad_index)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // forest model: clear to singletons with a saturated node count
  function automatic void clear_forest_model(input logic [COUNT_W-1:0] value);
    logic [COUNT_W-1:0] n;
    n = value;
    if (n == '0) n = COUNT_W'(1);
    if (n > COUNT_W'(MAX_NODES)) n = COUNT_W'(MAX_NODES);
    active_nodes = n;
    for (int i = 0; i < MAX_NODES; i++) begin
      parent_of[i] = NODE_W'(i);
      rank_of[i] = '0;
    end
    live_components = n;
  endfunction

  // root walk, then point every visited node straight at the root
  function automatic logic [NODE_W-1:0] find_root(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] nxt;
    int steps;
    r = n;
    steps = 0;
    while (parent_of[r] != r && steps < MAX_NODES) begin
      r = parent_of[r];
      steps++;
    end
    steps = 0;
    while (n != r && steps < MAX_NODES) begin
      nxt = parent_of[n];
      parent_of[n] = r;
      n = nxt;
      steps++;
    end
    return r;
  endfunction

  // one edge through the forest: union by rank, first root wins a tie
  function automatic kuf_result_t link_edge(input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b);
    kuf_result_t r;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    r.tree_edge = 1'b0;
    r.bad_index = 1'b0;
    if ({1'b0, a} >= active_nodes || {1'b0, b} >= active_nodes) begin
      r.bad_index = 1'b1;
      r.components_left = live_components;
      return r;
    end
    ra = find_root(a);
    rb = find_root(b);
    if (ra != rb) begin
      r.tree_edge = 1'b1;
      if (rank_of[ra] > rank_of[rb]) begin
        parent_of[rb] = ra;
      end else if (rank_of[rb] > rank_of[ra]) begin
        parent_of[ra] = rb;
      end else begin
        parent_of[rb] = ra;
        if (rank_of[ra] < RANK_MAX) rank_of[ra] = rank_of[ra] + 1'b1;
      end
      if (live_components > COUNT_W'(1)) live_components = live_components - 1'b1;
    end
    r.components_left = live_components;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, exp);
    mismatches++;
  endtask

  // send one edge word, with a random gap ahead of it
  task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 34) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    first_node <= a;
    second_node <= b;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, link_edge(a, b)};
  endtask

  // hold off the sender until every result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [COUNT_W-1:0] value);
    drain_results();
    node_count_we <= 1'b1;
    node_count <= value;
    @(posedge clk);
    node_count_we <= 1'b0;
    clear_forest_model(value);
  endtask

  // random edge, now and then with an endpoint out of range
  task automatic send_random_edge();
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    a = NODE_W'($urandom_range(0, active_nodes - 1));
    b = NODE_W'($urandom_range(0, active_nodes - 1));
    if (active_nodes < MAX_NODES && $urandom_range(0, 99) < 10) begin
      case ($urandom_range(0, 2))
        0: a = NODE_W'($urandom_range(active_nodes, MAX_NODES - 1));
        1: b = NODE_W'($urandom_range(active_nodes, MAX_NODES - 1));
        default: begin
          a = NODE_W'($urandom_range(active_nodes, MAX_NODES - 1));
          b = NODE_W'($urandom_range(active_nodes, MAX_NODES - 1));
        end
      endcase
    end
    send_edge(a, b);
  endtask

  // result side: random stalls, compare against the oldest prediction
  always @(posedge clk) begin
    out_ready <= steady_flow || ($urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin
    kuf_result_t exp_word;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with none pending", 1, 0);
      end else begin
        exp_word = pending_results.pop_front();
        if (tree_edge !== exp_word.tree_edge)
          report_mismatch("tree_edge", tree_edge, exp_word.tree_edge);
        if (components_left !== exp_word.components_left)
          report_mismatch("components_left", components_left, exp_word.components_left);
        if (bad_index !== exp_word.bad_index)
          report_mismatch("bad_index", bad_index, exp_word.bad_index);
      end
    end
  end

  // full forest after reset: field extremes, reversed edge, self loop
  task automatic test_reset_forest();
    send_edge(10'd0, 10'd1023);
    send_edge(10'd1023, 10'd0);
    send_edge(10'd512, 10'd512);
  endtask

  // node count saturation at both ends and tiny forests
  task automatic test_node_count_limits();
    write_node_count(11'd0);
    send_edge(10'd0, 10'd0);
    send_edge(10'd0, 10'd1);
    send_edge(10'd1023, 10'd1023);
    write_node_count(11'd2047);
    send_edge(10'd1023, 10'd1022);
    write_node_count(11'd2);
    send_edge(10'd0, 10'd1);
    send_edge(10'd1, 10'd2);
    write_node_count(11'd1025);
    send_edge(10'd1023, 10'd0);
  endtask

  // equal-rank merges up to rank 3, deep path compression, rank ordering
  task automatic test_rank_linking();
    write_node_count(11'd16);
    send_edge(10'd0, 10'd1);
    send_edge(10'd2, 10'd3);
    send_edge(10'd0, 10'd2);
    send_edge(10'd4, 10'd5);
    send_edge(10'd6, 10'd7);
    send_edge(10'd4, 10'd6);
    send_edge(10'd0, 10'd4);
    send_edge(10'd7, 10'd1);
    send_edge(10'd3, 10'd15);
    send_edge(10'd8, 10'd15);
    send_edge(10'd16, 10'd0);
  endtask

  // random edge streams over forests of many sizes
  task automatic test_random_forests();
    logic [COUNT_W-1:0] sizes [16];
    int items;
    sizes = '{11'd1, 11'd2, 11'd3, 11'd5, 11'd8, 11'd17, 11'd33, 11'd64,
              11'd100, 11'd257, 11'd513, 11'd1000, 11'd1024, 11'd2047, 11'd0, 11'd12};
    for (int p = 0; p < 16; p++) begin
      write_node_count(sizes[p]);
      items = $urandom_range(45, 75);
      for (int i = 0; i < items; i++) send_random_edge();
    end
    // a few more forests of random size
    for (int p = 0; p < 3; p++) begin
      write_node_count(COUNT_W'($urandom_range(4, 48)));
      for (int i = 0; i < 60; i++) send_random_edge();
    end
  endtask

  // back-to-back words with no gaps and no stalls
  task automatic test_steady_stream();
    write_node_count(11'd40);
    steady_flow = 1'b1;
    for (int i = 0; i < 200; i++) send_random_edge();
    drain_results();
    steady_flow = 1'b0;
  endtask

  initial begin
    clear_forest_model(COUNT_W'(MAX_NODES));
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_forest();
    test_node_count_limits();
    test_rank_linking();
    test_random_forests();
    test_steady_stream();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/kuf_pkg.sv
hdl/kuf_mem.sv
hdl/kuf_ctrl.sv
hdl/kruskal_union_find_forest.sv
tb/testbench.sv
